[rtl/mpm_pkg.sv]
// ----------------------------------------------------------------------------
// mpm_pkg: shared types and codes of the multi-pattern matcher
// Holds the operation and status codes used by the matcher files.
// ----------------------------------------------------------------------------
package mpm_pkg;

  localparam int ModeW = 3;
  localparam int LetterW = 5;
  localparam int QueryW = 8;
  localparam int StatusW = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_PAT_LETTER = 3'd0,
    MODE_PAT_END    = 3'd1,
    MODE_BUILD      = 3'd2,
    MODE_TEXT       = 3'd3,
    MODE_QUERY      = 3'd4
  } mode_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK           = 2'd0,
    ST_NODES_FULL   = 2'd1,
    ST_PATTERNS_FULL = 2'd2,
    ST_PHASE        = 2'd3
  } status_t;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [LetterW-1:0] letter;
    logic [QueryW-1:0]  query_index;
  } req_t;

  typedef struct packed {
    logic          found;
    logic [StatusW-1:0] status;
  } rsp_t;

endpackage

[rtl/mpm_req_if.sv]
// ----------------------------------------------------------------------------
// mpm_req_if: request channel
// Valid/ready channel that carries one command beat.
// ----------------------------------------------------------------------------
interface mpm_req_if;
  logic valid;
  logic ready;
  logic [2:0] mode;
  logic [4:0] letter;
  logic [7:0] query_index;
  modport source (output valid, output mode, output letter, output query_index,
                  input ready);
  modport sink (input valid, input mode, input letter, input query_index,
                output ready);
endinterface

[rtl/mpm_rsp_if.sv]
// ----------------------------------------------------------------------------
// mpm_rsp_if: response channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface mpm_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic [1:0] status;
  modport source (output valid, output found, output status, input ready);
  modport sink (input valid, input found, input status, output ready);
endinterface

[rtl/mpm_out_reg.sv]
// ----------------------------------------------------------------------------
// mpm_out_reg: result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module mpm_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  mpm_pkg::rsp_t  load_data,
  output logic           full,
  mpm_rsp_if.source      rsp
);
  import mpm_pkg::*;

  rsp_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (rsp.ready) begin
      full <= 1'b0;
    end
    if (load) begin
      data <= load_data;
    end
  end

  assign rsp.valid  = full;
  assign rsp.found  = data.found;
  assign rsp.status = data.status;
endmodule

[rtl/multi_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// multi_pattern_matcher: Aho-Corasick matcher over the letters a..z
// Trie, links and flags live in synchronous memories driven by one sequencer.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the req channel, one beat each: pattern letters
// (mode 0), end of pattern (mode 1), build (mode 2), text letters (mode 3)
// and flag queries (mode 4). Every command gives exactly one beat on the rsp
// channel with found and status.
// Operation. One command is worked on at a time. A text letter reads the
// transition memory and then walks the output links node by node. The build
// reads the root row, then for each queued node reads every letter slot and,
// per child, its fail target. Each step waits on the registered read data of
// the transition memory, whose single port is shared.
// Reset. After rst a clearing pass writes zero into every entry of the
// transition memory and the per-node memories, one entry a cycle; no command
// is taken until the pass is done.
// Stall. The result sits in an output register; a new command is taken once
// the sequencer is idle, no result is being loaded, and that register is free
// or being read.
// ----------------------------------------------------------------------------
module multi_pattern_matcher #(
  parameter int MAX_NODES    = 1024,
  parameter int ALPHABET     = 26,
  parameter int MAX_PATTERNS = 256
) (
  input logic       clk,
  input logic       rst,
  mpm_req_if.sink   req,
  mpm_rsp_if.source rsp
);
  import mpm_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int TDEPTH = MAX_NODES * ALPHABET;
  localparam int TW = $clog2(TDEPTH);
  localparam int PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_INS_RD, S_INS_WR, S_END_RD, S_TXT_RD, S_TXT_NODE,
    S_WALK, S_Q_RD, S_B_ROOT, S_B_ROOT_RD, S_B_QWAIT, S_B_POP, S_B_POP_RD,
    S_B_CH, S_B_CH_RD, S_B_F, S_B_F_RD, S_B_OUT_RD, S_DONE
  } state_t;

  // Memories.
  logic [NW-1:0] trans_mem [TDEPTH];
  logic          term_mem  [MAX_NODES];
  logic [PW-1:0] pat_mem   [MAX_NODES];
  logic [NW-1:0] fail_mem  [MAX_NODES];
  logic [NW-1:0] out_mem   [MAX_NODES];
  logic [NW-1:0] queue_mem [MAX_NODES];
  logic          found_mem [MAX_PATTERNS];

  // Registered read data.
  logic [NW-1:0] t_rd, fail_rd, out_rd, q_rd;
  logic          term_rd, found_rd;
  logic [PW-1:0] pat_rd;

  // Ports driven by the sequencer.
  logic [TW-1:0] t_addr;
  logic          t_we;
  logic [NW-1:0] t_wd;
  logic [NW-1:0] n_addr;
  logic          term_we, pat_we, fail_we, out_we;
  logic          term_wd;
  logic [PW-1:0] pat_wd;
  logic [NW-1:0] fail_wd, out_wd;
  logic [NW-1:0] q_waddr, q_raddr, q_wd;
  logic          q_we;
  logic [PW-1:0] f_addr;
  logic          f_we;

  state_t        state;
  logic [TW:0]   clr_cnt;
  logic [NW:0]   node_count;
  logic [PW:0]   pattern_count;
  logic [NW-1:0] insert_node, match_state, cur, u, fu, v, f;
  logic [CW-1:0] c;
  logic [NW:0]   head, tail;
  logic          built;
  logic [ModeW-1:0]   cmd_mode;
  logic [LetterW-1:0] cmd_letter;
  logic [QueryW-1:0]  cmd_query;
  logic          rsp_load, rsp_full;
  rsp_t          rsp_data;
  logic          clearing;
  status_t       acc_status;
  state_t        acc_state;

  function automatic logic [TW-1:0] taddr(logic [NW-1:0] n, logic [CW-1:0] l);
    logic [TW+CW:0] p;
    p = (TW+CW+1)'(n) * (TW+CW+1)'(ALPHABET) + (TW+CW+1)'(l);
    return p[TW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (t_we) trans_mem[t_addr] <= t_wd;
    t_rd <= trans_mem[t_addr];
    if (term_we) term_mem[n_addr] <= term_wd;
    if (pat_we)  pat_mem[n_addr]  <= pat_wd;
    if (fail_we) fail_mem[n_addr] <= fail_wd;
    if (out_we)  out_mem[n_addr]  <= out_wd;
    term_rd <= term_mem[n_addr];
    pat_rd  <= pat_mem[n_addr];
    fail_rd <= fail_mem[n_addr];
    out_rd  <= out_mem[n_addr];
    if (q_we) queue_mem[q_waddr] <= q_wd;
    q_rd <= queue_mem[q_raddr];
    if (f_we) found_mem[f_addr] <= !clearing;
    found_rd <= found_mem[f_addr];
  end

  wire accept = req.valid && req.ready;
  // A result that is being loaded this cycle still has to leave the output
  // register before the next command may finish.
  assign req.ready = (state == S_IDLE) && !rsp_load && (!rsp_full || rsp.ready);
  assign clearing = (state == S_CLEAR);
  wire letter_ok = (32'(cmd_letter) < ALPHABET);
  wire [CW-1:0] cmd_c = cmd_letter[CW-1:0];

  // Status and first state of an accepted command.
  always_comb begin
    acc_status = ST_OK;
    acc_state = S_DONE;
    unique case (req.mode)
      MODE_PAT_LETTER: if (built) acc_status = ST_PHASE;
                       else if (32'(req.letter) < ALPHABET) acc_state = S_INS_RD;
      MODE_PAT_END: if (built) acc_status = ST_PHASE;
                    else if (pattern_count >= (PW+1)'(MAX_PATTERNS))
                      acc_status = ST_PATTERNS_FULL;
                    else acc_state = S_END_RD;
      MODE_BUILD: if (built) acc_status = ST_PHASE;
                  else acc_state = S_B_ROOT;
      MODE_TEXT: if (!built) acc_status = ST_PHASE;
                 else acc_state = S_TXT_RD;
      MODE_QUERY: if (32'(req.query_index) < MAX_PATTERNS) acc_state = S_Q_RD;
      default: acc_status = ST_PHASE;
    endcase
  end

  // Memory port control, decoded from the state.
  always_comb begin
    t_addr = '0; t_we = 1'b0; t_wd = '0;
    n_addr = '0; term_we = 1'b0; pat_we = 1'b0; fail_we = 1'b0; out_we = 1'b0;
    term_wd = 1'b0; pat_wd = '0; fail_wd = '0; out_wd = '0;
    q_waddr = tail[NW-1:0]; q_raddr = head[NW-1:0]; q_we = 1'b0; q_wd = v;
    f_addr = '0; f_we = 1'b0;
    unique case (state)
      S_CLEAR: begin
        t_addr = clr_cnt[TW-1:0]; t_we = 1'b1;
        n_addr = clr_cnt[NW-1:0];
        term_we = (clr_cnt < (TW+1)'(MAX_NODES));
        pat_we = term_we; fail_we = term_we; out_we = term_we;
        f_addr = clr_cnt[PW-1:0];
        f_we = (clr_cnt < (TW+1)'(MAX_PATTERNS));
      end
      S_INS_RD: t_addr = taddr(insert_node, cmd_c);
      S_INS_WR: begin
        t_addr = taddr(insert_node, cmd_c);
        t_we = (t_rd == '0) && (node_count < (NW+1)'(MAX_NODES));
        t_wd = node_count[NW-1:0];
      end
      S_END_RD: begin
        n_addr = insert_node; term_we = 1'b1; term_wd = 1'b1;
        pat_we = 1'b1; pat_wd = pattern_count[PW-1:0];
      end
      S_TXT_RD: t_addr = taddr(match_state, cmd_c);
      S_TXT_NODE: n_addr = t_rd;
      S_WALK: begin
        n_addr = out_rd;
        f_addr = pat_rd;
        f_we = (cur != '0) && term_rd;
      end
      S_Q_RD: f_addr = cmd_query[PW-1:0];
      S_B_ROOT: t_addr = taddr('0, c);
      S_B_ROOT_RD: begin
        n_addr = t_rd; fail_we = (t_rd != '0); out_we = fail_we;
        q_we = (t_rd != '0) && (tail < (NW+1)'(MAX_NODES)); q_wd = t_rd;
      end
      S_B_POP: n_addr = q_rd;
      S_B_POP_RD: ;
      S_B_CH: t_addr = taddr(u, c);
      S_B_CH_RD: t_addr = taddr(fu, c);
      S_B_F: begin
        if (v == '0) begin
          t_addr = taddr(u, c); t_we = 1'b1; t_wd = t_rd;
        end else begin
          n_addr = t_rd;
        end
      end
      S_B_F_RD: begin
        n_addr = v; fail_we = 1'b1; fail_wd = f;
        out_we = 1'b1; out_wd = term_rd ? f : out_rd;
        q_we = (tail < (NW+1)'(MAX_NODES));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_cnt <= '0; node_count <= (NW+1)'(1);
      pattern_count <= '0; insert_node <= '0; match_state <= '0;
      built <= 1'b0; rsp_load <= 1'b0;
    end else begin
      rsp_load <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (TW+1)'(TDEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          cmd_mode <= req.mode; cmd_letter <= req.letter;
          cmd_query <= req.query_index;
          rsp_data <= '{found: 1'b0, status: acc_status};
          state <= acc_state;
          if (acc_status == ST_PATTERNS_FULL) insert_node <= '0;
          if (acc_state == S_B_ROOT) begin
            c <= '0; head <= '0; tail <= '0;
          end
        end
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          if (t_rd != '0) insert_node <= t_rd;
          else if (node_count >= (NW+1)'(MAX_NODES)) rsp_data.status <= ST_NODES_FULL;
          else begin
            insert_node <= node_count[NW-1:0]; node_count <= node_count + 1'b1;
          end
          state <= S_DONE;
        end
        S_END_RD: begin
          pattern_count <= pattern_count + 1'b1; insert_node <= '0; state <= S_DONE;
        end
        S_TXT_RD: if (!letter_ok) begin
          match_state <= '0; state <= S_DONE;
        end else state <= S_TXT_NODE;
        S_TXT_NODE: begin
          // The transition read issued in S_TXT_RD has landed.
          match_state <= t_rd; cur <= t_rd;
          state <= S_WALK;
        end
        S_WALK: begin
          // cur holds the node whose term/pat/out data is in the read regs.
          if (cur == '0) state <= S_DONE;
          else cur <= out_rd;
        end
        S_Q_RD: state <= S_DONE;
        S_B_ROOT: state <= S_B_ROOT_RD;
        S_B_ROOT_RD: begin
          if (t_rd != '0 && tail < (NW+1)'(MAX_NODES)) tail <= tail + 1'b1;
          if (32'(c) == ALPHABET - 1) state <= S_B_QWAIT;
          else begin c <= c + 1'b1; state <= S_B_ROOT; end
        end
        // A wait state, so that the last queue entry written is read back.
        S_B_QWAIT: state <= S_B_POP;
        S_B_POP: if (head >= tail) begin
          built <= 1'b1; match_state <= '0; state <= S_DONE;
        end else begin
          u <= q_rd; head <= head + 1'b1; state <= S_B_POP_RD;
        end
        S_B_POP_RD: begin fu <= fail_rd; c <= '0; state <= S_B_CH; end
        S_B_CH: state <= S_B_CH_RD;
        S_B_CH_RD: begin v <= t_rd; state <= S_B_F; end
        S_B_F: if (v == '0) begin
          if (32'(c) == ALPHABET - 1) state <= S_B_POP;
          else begin c <= c + 1'b1; state <= S_B_CH; end
        end else begin
          f <= t_rd; state <= S_B_F_RD;
        end
        S_B_F_RD: begin
          if (tail < (NW+1)'(MAX_NODES)) tail <= tail + 1'b1;
          if (32'(c) == ALPHABET - 1) state <= S_B_QWAIT;
          else begin c <= c + 1'b1; state <= S_B_CH; end
        end
        S_DONE: begin
          if (cmd_mode == MODE_QUERY && rsp_data.status == ST_OK &&
              32'(cmd_query) < MAX_PATTERNS) rsp_data.found <= found_rd;
          rsp_load <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mpm_out_reg u_out (
    .clk(clk), .rst(rst), .load(rsp_load),
    .load_data(rsp_data), .full(rsp_full), .rsp(rsp)
  );
endmodule
